FILE: design/abpp_pkg.sv
// ----------------------------------------------------------------------------
// abpp_pkg
// Shared types and constants for the alpha-blend pixel packer.
// ----------------------------------------------------------------------------
`default_nettype none

package abpp_pkg;

	// register port geometry: eight 32-bit registers at 4-byte steps
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// channel slots in the per-channel arrays
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int NUM_CH   = 3;

	// default channel masks
	localparam logic [31:0] MASK15_RED   = 32'h0000_7C00;
	localparam logic [31:0] MASK15_GREEN = 32'h0000_03E0;
	localparam logic [31:0] MASK15_BLUE  = 32'h0000_001F;
	localparam logic [31:0] MASK16_RED   = 32'h0000_F800;
	localparam logic [31:0] MASK16_GREEN = 32'h0000_07E0;
	localparam logic [31:0] MASK16_BLUE  = 32'h0000_001F;
	localparam logic [31:0] MASK24_RED   = 32'h00FF_0000;
	localparam logic [31:0] MASK24_GREEN = 32'h0000_FF00;
	localparam logic [31:0] MASK24_BLUE  = 32'h0000_00FF;

	// blend and scale constants
	localparam logic [7:0]  ALPHA_FULL = 8'd255;
	localparam logic [31:0] ROUND_HALF = 32'd127;
	// 2^39 / 255 rounded up: exact divide by 255 for any 32-bit word
	localparam logic [63:0] RECIP_255  = 64'h0000_0000_8080_8081;

	// register settings; user keeps them stable while items fly, unenforced
	typedef struct packed {
		logic [7:0]                 bg_red;
		logic [7:0]                 bg_green;
		logic [7:0]                 bg_blue;
		logic [NUM_CH-1:0][4:0]     shift;
		logic [NUM_CH-1:0][31:0]    maxv;
		logic [3:0]                 bpb;
		logic                       usable;
		logic [14:0]                screen_width;
		logic [14:0]                screen_height;
		logic [20:0]                line_pitch;
	} cfg_t;

	// one classified pixel waiting for the back end
	typedef struct packed {
		logic [15:0] dest_x;
		logic [15:0] dest_y;
		logic [7:0]  src_blue;
		logic [7:0]  src_green;
		logic [7:0]  src_red;
		logic [7:0]  src_alpha;
		logic        on_screen;
	} item_t;

endpackage

`default_nettype wire

FILE: design/abpp_if.sv
// ----------------------------------------------------------------------------
// abpp_if
// Valid/ready channels for source pixels and packed framebuffer words.
// ----------------------------------------------------------------------------
`default_nettype none

interface abpp_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] dest_x;
	logic [15:0] dest_y;
	logic [7:0]  src_blue;
	logic [7:0]  src_green;
	logic [7:0]  src_red;
	logic [7:0]  src_alpha;

	modport source (
		output valid, dest_x, dest_y, src_blue, src_green, src_red, src_alpha,
		input  ready
	);
	modport sink (
		input  valid, dest_x, dest_y, src_blue, src_green, src_red, src_alpha,
		output ready
	);
endinterface

interface abpp_out_if;
	logic        valid;
	logic        ready;
	logic        inside_res;
	logic [27:0] byte_address;
	logic [2:0]  byte_count;
	logic [31:0] pixel_value;

	modport source (
		output valid, inside_res, byte_address, byte_count, pixel_value,
		input  ready
	);
	modport sink (
		input  valid, inside_res, byte_address, byte_count, pixel_value,
		output ready
	);
endinterface

`default_nettype wire

FILE: design/abpp_cfg.sv
// ----------------------------------------------------------------------------
// abpp_cfg
// Register file on the APB port plus the per-channel shift and full-scale
// values derived from the masks. Holds the input off while those settle.
// ----------------------------------------------------------------------------
`default_nettype none

module abpp_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [abpp_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [abpp_pkg::APB_DATA_W-1:0] pwdata,
	output      logic [abpp_pkg::APB_DATA_W-1:0] prdata,
	output      logic                            pready,
	output      abpp_pkg::cfg_t                  cfg,
	output      logic                            settled
);
	import abpp_pkg::*;

	localparam logic [2:0] REG_BG     = 3'd0;
	localparam logic [2:0] REG_RMASK  = 3'd1;
	localparam logic [2:0] REG_GMASK  = 3'd2;
	localparam logic [2:0] REG_BMASK  = 3'd3;
	localparam logic [2:0] REG_BPP    = 3'd4;
	localparam logic [2:0] REG_WIDTH  = 3'd5;
	localparam logic [2:0] REG_HEIGHT = 3'd6;
	localparam logic [2:0] REG_PITCH  = 3'd7;

	// derived values pass eff_mask_q, then shift_q and mask2_q, then maxv_q after a write
	localparam logic [1:0] SETTLE_CYCLES = 2'd3;

	logic [23:0] bg_q;
	logic [31:0] rmask_q;
	logic [31:0] gmask_q;
	logic [31:0] bmask_q;
	logic [5:0]  bpp_q;
	logic [14:0] width_q;
	logic [14:0] height_q;
	logic [20:0] pitch_q;
	logic [1:0]  settle_q;

	logic [2:0]  reg_idx;
	logic        wr_en;

	logic [NUM_CH-1:0][31:0] eff_mask;
	logic [NUM_CH-1:0][31:0] eff_mask_q;
	logic [NUM_CH-1:0][31:0] mask2_q;
	logic [NUM_CH-1:0][4:0]  low_idx;
	logic [NUM_CH-1:0][4:0]  shift_q;
	logic [NUM_CH-1:0][31:0] maxv_q;
	logic [NUM_CH-1:0][31:0] work;
	logic [NUM_CH-1:0][31:0] run;
	logic [6:0]              bpp_sum;
	logic [3:0]              bpb;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q     <= '0;
			rmask_q  <= '0;
			gmask_q  <= '0;
			bmask_q  <= '0;
			bpp_q    <= 6'd32;
			width_q  <= 15'd1024;
			height_q <= 15'd768;
			pitch_q  <= 21'd4096;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_BG:     bg_q     <= pwdata[23:0];
				REG_RMASK:  rmask_q  <= pwdata;
				REG_GMASK:  gmask_q  <= pwdata;
				REG_BMASK:  bmask_q  <= pwdata;
				REG_BPP:    bpp_q    <= pwdata[5:0];
				REG_WIDTH:  width_q  <= pwdata[14:0];
				REG_HEIGHT: height_q <= pwdata[14:0];
				REG_PITCH:  pitch_q  <= pwdata[20:0];
				default:    bg_q     <= bg_q;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_BG:     prdata = {8'd0, bg_q};
			REG_RMASK:  prdata = rmask_q;
			REG_GMASK:  prdata = gmask_q;
			REG_BMASK:  prdata = bmask_q;
			REG_BPP:    prdata = {26'd0, bpp_q};
			REG_WIDTH:  prdata = {17'd0, width_q};
			REG_HEIGHT: prdata = {17'd0, height_q};
			REG_PITCH:  prdata = {11'd0, pitch_q};
			default:    prdata = '0;
		endcase
	end

	// settle counter: input held off after reset and after every write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_CYCLES;
		end else if (wr_en) begin
			settle_q <= SETTLE_CYCLES;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	assign settled = (settle_q == 2'd0);

	// effective masks: any zero mask selects the depth defaults
	always_comb begin
		priority if (rmask_q != '0 && gmask_q != '0 && bmask_q != '0) begin
			eff_mask[CH_RED]   = rmask_q;
			eff_mask[CH_GREEN] = gmask_q;
			eff_mask[CH_BLUE]  = bmask_q;
		end else if (bpp_q == 6'd15) begin
			eff_mask[CH_RED]   = MASK15_RED;
			eff_mask[CH_GREEN] = MASK15_GREEN;
			eff_mask[CH_BLUE]  = MASK15_BLUE;
		end else if (bpp_q == 6'd16) begin
			eff_mask[CH_RED]   = MASK16_RED;
			eff_mask[CH_GREEN] = MASK16_GREEN;
			eff_mask[CH_BLUE]  = MASK16_BLUE;
		end else begin
			eff_mask[CH_RED]   = MASK24_RED;
			eff_mask[CH_GREEN] = MASK24_GREEN;
			eff_mask[CH_BLUE]  = MASK24_BLUE;
		end
	end

	// position of the lowest set bit of each mask
	always_comb begin
		logic [31:0] low;
		for (int c = 0; c < NUM_CH; c++) begin
			low        = eff_mask_q[c] & (~eff_mask_q[c] + 32'd1);
			low_idx[c] = '0;
			for (int i = 0; i < 32; i++) begin
				if (low[i]) begin
					low_idx[c] = low_idx[c] | 5'(i);
				end
			end
		end
	end

	// run of ones above the shift; 31 bits or more means all ones
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			work[c] = mask2_q[c] >> shift_q[c];
			run[c]  = work[c] & ~(work[c] + 32'd1);
		end
	end

	// derivation stages
	always_ff @(posedge clk) begin
		eff_mask_q <= eff_mask;
		mask2_q    <= eff_mask_q;
		shift_q    <= low_idx;
		for (int c = 0; c < NUM_CH; c++) begin
			maxv_q[c] <= run[c][30] ? '1 : run[c];
		end
	end

	assign bpp_sum = {1'b0, bpp_q} + 7'd7;
	assign bpb     = bpp_sum[6:3];

	always_comb begin
		cfg.bg_red        = bg_q[23:16];
		cfg.bg_green      = bg_q[15:8];
		cfg.bg_blue       = bg_q[7:0];
		cfg.shift         = shift_q;
		cfg.maxv          = maxv_q;
		cfg.bpb           = bpb;
		cfg.usable        = (bpb >= 4'd2) && (bpb <= 4'd4);
		cfg.screen_width  = width_q;
		cfg.screen_height = height_q;
		cfg.line_pitch    = pitch_q;
	end

endmodule

`default_nettype wire

FILE: design/abpp_front.sv
// ----------------------------------------------------------------------------
// abpp_front
// Takes source pixels, clips them against the screen and hands them to the
// queue in front of the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module abpp_front (
	input  wire logic           settled,
	input  wire abpp_pkg::cfg_t cfg,
	abpp_in_if.sink             src_pix,
	output      logic           push_valid,
	input  wire logic           push_ready,
	output      abpp_pkg::item_t push_item
);
	import abpp_pkg::*;

	logic x_ok;
	logic y_ok;

	// input stalls while the queue is full or settings are settling
	assign src_pix.ready = push_ready && settled;
	assign push_valid    = src_pix.valid && settled;

	// clip against the visible area
	assign x_ok = src_pix.dest_x < {1'b0, cfg.screen_width};
	assign y_ok = src_pix.dest_y < {1'b0, cfg.screen_height};

	always_comb begin
		push_item.dest_x    = src_pix.dest_x;
		push_item.dest_y    = src_pix.dest_y;
		push_item.src_blue  = src_pix.src_blue;
		push_item.src_green = src_pix.src_green;
		push_item.src_red   = src_pix.src_red;
		push_item.src_alpha = src_pix.src_alpha;
		push_item.on_screen = x_ok && y_ok && cfg.usable;
	end

endmodule

`default_nettype wire

FILE: design/abpp_queue.sv
// ----------------------------------------------------------------------------
// abpp_queue
// Small flop queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module abpp_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output      logic            push_ready,
	input  wire abpp_pkg::item_t push_item,
	output      logic            pop_valid,
	input  wire logic            pop_ready,
	output      abpp_pkg::item_t pop_item
);
	import abpp_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	item_t            slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = slot_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/abpp_back.sv
// ----------------------------------------------------------------------------
// abpp_back
// Five-stage blend, scale and pack pipeline with the address computation
// alongside. All stages advance together when the output word moves or the output register is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module abpp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire abpp_pkg::cfg_t  cfg,
	input  wire logic            q_valid,
	output      logic            q_ready,
	input  wire abpp_pkg::item_t q_item,
	abpp_out_if.source           packed_pix
);
	import abpp_pkg::*;

	// src*a + bg*(255-a), at most 65025
	function automatic logic [16:0] blend_sum(
		input logic [7:0] s,
		input logic [7:0] bg,
		input logic [7:0] a
	);
		logic [15:0] p_src;
		logic [15:0] p_bg;
		p_src = s * a;
		p_bg  = bg * (ALPHA_FULL - a);
		return {1'b0, p_src} + {1'b0, p_bg};
	endfunction

	// exact floor(s/255) for s below 65280
	function automatic logic [7:0] div255_narrow(input logic [16:0] s);
		logic [16:0] t;
		t = s + 17'd1 + {8'd0, s[16:8]};
		return t[15:8];
	endfunction

	logic en;

	logic                     v_s1, v_s2, v_s3, v_s4, v_q;
	logic [NUM_CH-1:0][16:0]  sum_s1;
	logic [NUM_CH-1:0][7:0]   val_s2;
	logic [NUM_CH-1:0][31:0]  num_s3;
	logic [NUM_CH-1:0][24:0]  quo_s4;
	logic [27:0]              ya_s1;
	logic [19:0]              xa_s1;
	logic [27:0]              addr_s2, addr_s3, addr_s4;
	logic                     in_s1, in_s2, in_s3, in_s4;

	logic [36:0]              y_prod;
	logic [NUM_CH-1:0][31:0]  scaled;
	logic [NUM_CH-1:0][63:0]  recip;
	logic [31:0]              pix;

	logic                     inside_q;
	logic [27:0]              addr_q;
	logic [2:0]               count_q;
	logic [31:0]              pix_q;

	// whole pipe moves when the output register is free or being taken
	assign en      = !v_q || packed_pix.ready;
	assign q_ready = en;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_q  <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_q  <= v_s4;
		end
	end

	assign y_prod = q_item.dest_y * cfg.line_pitch;

	// stage 1: blend products and address products
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1[CH_RED]   <= blend_sum(q_item.src_red, cfg.bg_red, q_item.src_alpha);
			sum_s1[CH_GREEN] <= blend_sum(q_item.src_green, cfg.bg_green, q_item.src_alpha);
			sum_s1[CH_BLUE]  <= blend_sum(q_item.src_blue, cfg.bg_blue, q_item.src_alpha);
			ya_s1            <= y_prod[27:0];
			xa_s1            <= q_item.dest_x * cfg.bpb;
			in_s1            <= q_item.on_screen;
		end
	end

	// stage 2: divide by 255, sum the address
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NUM_CH; c++) begin
				val_s2[c] <= div255_narrow(sum_s1[c]);
			end
			addr_s2 <= ya_s1 + {8'd0, xa_s1};
			in_s2   <= in_s1;
		end
	end

	// stage 3: scale to channel full range, wrapping at 32 bits
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			scaled[c] = cfg.maxv[c] * {24'd0, val_s2[c]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NUM_CH; c++) begin
				num_s3[c] <= scaled[c] + ROUND_HALF;
			end
			addr_s3 <= addr_s2;
			in_s3   <= in_s2;
		end
	end

	// stage 4: divide by 255 through the reciprocal
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			recip[c] = {32'd0, num_s3[c]} * RECIP_255;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NUM_CH; c++) begin
				quo_s4[c] <= recip[c][63:39];
			end
			addr_s4 <= addr_s3;
			in_s4   <= in_s3;
		end
	end

	// stage 5: shift into place and merge
	always_comb begin
		pix = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			pix = pix | ({7'd0, quo_s4[c]} << cfg.shift[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_q <= in_s4;
			addr_q   <= addr_s4;
			count_q  <= cfg.usable ? cfg.bpb[2:0] : 3'd0;
			pix_q    <= pix;
		end
	end

	assign packed_pix.valid        = v_q;
	assign packed_pix.inside_res   = inside_q;
	assign packed_pix.byte_address = addr_q;
	assign packed_pix.byte_count   = count_q;
	assign packed_pix.pixel_value  = pix_q;

endmodule

`default_nettype wire

FILE: design/alpha_blend_pixel_packer.sv
// Path: an accepted pixel enters the queue, then passes the five back-end
//   stages, the last of which holds the output word.
// Throughput: one pixel per clock while nothing stalls; the back end's five
//   registered stages and four-entry queue let both sides stall independently.
// Reset: asynchronous, active low; registers take their reset values, and the
//   input is held off after reset and each register write until settings settle.
// ----------------------------------------------------------------------------
// alpha_blend_pixel_packer
// Blends a source pixel over the background color, packs it into the
// framebuffer format and produces its byte address, byte count and clip flag.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_blend_pixel_packer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [abpp_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [abpp_pkg::APB_DATA_W-1:0] pwdata,
	output      logic [abpp_pkg::APB_DATA_W-1:0] prdata,
	output      logic                            pready,
	abpp_in_if.sink                              src_pix,
	abpp_out_if.source                           packed_pix
);
	import abpp_pkg::*;

	cfg_t  cfg;
	logic  settled;
	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	abpp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.settled (settled)
	);

	abpp_front u_front (
		.settled    (settled),
		.cfg        (cfg),
		.src_pix    (src_pix),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	abpp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	abpp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_valid    (pop_valid),
		.q_ready    (pop_ready),
		.q_item     (pop_item),
		.packed_pix (packed_pix)
	);

endmodule

`default_nettype wire

FILE: design/abpp_checker.sv
// ----------------------------------------------------------------------------
// abpp_checker
// Port-level checks for the pixel packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module abpp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        inside_res,
	input wire logic [27:0] byte_address,
	input wire logic [2:0]  byte_count,
	input wire logic [31:0] pixel_value
);

	// a stalled word stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_address)
			&& $stable(pixel_value) && $stable(inside_res))
		else $error("stalled output word changed");

	// no pixel is taken on the cycle after a register write
	assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite |=> !(in_valid && in_ready))
		else $error("pixel accepted while settings settle");

	// no pixel is taken on the first cycle out of reset
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !(in_valid && in_ready))
		else $error("pixel accepted right after reset");

	// byte count is zero or a usable depth
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_count == 3'd0 || byte_count == 3'd2
			|| byte_count == 3'd3 || byte_count == 3'd4)
		else $error("byte count out of range");

	// a pixel to be written always has bytes to write
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && inside_res |-> byte_count != 3'd0)
		else $error("inside pixel with zero byte count");

endmodule

bind alpha_blend_pixel_packer abpp_checker u_abpp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.in_valid     (src_pix.valid),
	.in_ready     (src_pix.ready),
	.out_valid    (packed_pix.valid),
	.out_ready    (packed_pix.ready),
	.inside_res   (packed_pix.inside_res),
	.byte_address (packed_pix.byte_address),
	.byte_count   (packed_pix.byte_count),
	.pixel_value  (packed_pix.pixel_value)
);

`default_nettype wire
